### rtl/dlc_pkg.sv
// Package for the Drude-Lorentz conductivity evaluator.
// Request and result types, codes, states, unit control structs.
// No dependencies.
package dlc_pkg;

  localparam int MAX_DRUDE_DEF   = 16;
  localparam int MAX_LORENTZ_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [1:0] KIND_DRUDE   = 2'd0;
  localparam logic [1:0] KIND_LORENTZ = 2'd1;
  localparam logic [1:0] KIND_EVAL    = 2'd2;

  localparam logic [1:0] CFG_DRUDE_TERMS   = 2'd0;
  localparam logic [1:0] CFG_LORENTZ_TERMS = 2'd1;
  localparam logic [1:0] CFG_NORMALIZATION = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic [31:0] value_third;
    logic [31:0] frequency;
  } req_t;

  typedef struct packed {
    logic [31:0] conductivity;
    logic        overflow;
  } res_t;

  typedef struct packed {
    logic       start;
    logic [2:0] na;
    logic [1:0] nb;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic big;
  } div_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_D_RD, S_D_M1, S_D_M2, S_D_M3, S_D_M4, S_D_DIV,
    S_L_RD, S_L_M1, S_L_M2, S_L_M3, S_L_M4, S_L_M5, S_L_M6, S_L_M7, S_L_M8,
    S_L_DIV,
    S_NORM, S_FIN
  } state_t;

endpackage

### rtl/drude_lorentz_conductivity_eval_top.sv
// Drude-Lorentz conductivity evaluator, top level. Depends on dlc_pkg, dlc_ram, dlc_mul, dlc_div.
// Evaluate requests run on the shared 32x32 limb multiplier and the one-bit-a-cycle divider.
// One request in work at a time; the next is taken while a result waits in the output register.
// Synchronous reset clears control, counts and normalisation (1.0); table contents stay
// undefined until loaded.
module drude_lorentz_conductivity_eval_top #(
  parameter int MAX_DRUDE   = dlc_pkg::MAX_DRUDE_DEF,
  parameter int MAX_LORENTZ = dlc_pkg::MAX_LORENTZ_DEF,
  parameter int FRAC_BITS   = dlc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dlc_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_stall,
  output dlc_pkg::res_t res_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int DAW = $clog2(MAX_DRUDE > 1 ? MAX_DRUDE : 2);
  localparam int LAW = $clog2(MAX_LORENTZ > 1 ? MAX_LORENTZ : 2);
  localparam logic [6:0] MAXD = 7'(MAX_DRUDE);
  localparam logic [6:0] MAXL = 7'(MAX_LORENTZ);

  dlc_pkg::state_t state, state_next;

  logic [4:0]   drude_terms;
  logic [4:0]   lorentz_terms;
  logic [31:0]  normalization;

  logic [6:0]   nd, nl, cnt, cnt_inc, idx_ext;
  logic         issued;
  logic [31:0]  w, ep, eg, es, ex;
  logic [63:0]  t1, t2;
  logic [127:0] t128;
  logic [159:0] num_r;
  logic [128:0] den_r;
  logic [63:0]  sum;
  logic [64:0]  sum_add;
  logic         sat;
  logic [31:0]  res_q;
  logic [63:0]  diff;

  logic         accept, res_load, mul_state, div_state;
  logic         dram_we, lram_we;
  logic [63:0]  dram_rdata;
  logic [95:0]  lram_rdata;

  dlc_pkg::mul_req_t  mul_ctl;
  logic [127:0]       mul_a;
  logic [63:0]        mul_b;
  logic               mul_done;
  logic [191:0]       mul_p;
  logic               div_start;
  logic [159:0]       div_n;
  logic [128:0]       div_d;
  dlc_pkg::div_stat_t div_st;
  logic [63:0]        div_q;

  assign nd = ({2'd0, drude_terms} > MAXD) ? MAXD : {2'd0, drude_terms};
  assign nl = ({2'd0, lorentz_terms} > MAXL) ? MAXL : {2'd0, lorentz_terms};
  assign idx_ext = 7'(req_data.entry_index);
  assign cnt_inc = cnt + 7'd1;
  assign accept = req_valid && !req_stall;
  assign req_stall = (state != dlc_pkg::S_IDLE);
  assign dram_we = accept && req_data.kind == dlc_pkg::KIND_DRUDE && idx_ext < MAXD;
  assign lram_we = accept && req_data.kind == dlc_pkg::KIND_LORENTZ && idx_ext < MAXL;
  assign sum_add = {1'b0, sum} + {1'b0, div_q};
  assign diff = (t2 >= mul_p[63:0]) ? t2 - mul_p[63:0] : mul_p[63:0] - t2;
  assign res_load = (state == dlc_pkg::S_FIN) && (!res_valid || !res_stall);

  dlc_ram #(.WIDTH(64), .DEPTH(MAX_DRUDE)) u_dram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (idx_ext[DAW-1:0]),
    .wdata ({req_data.value_first, req_data.value_second}),
    .raddr (cnt[DAW-1:0]),
    .rdata (dram_rdata)
  );

  dlc_ram #(.WIDTH(96), .DEPTH(MAX_LORENTZ)) u_lram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (idx_ext[LAW-1:0]),
    .wdata ({req_data.value_first, req_data.value_second, req_data.value_third}),
    .raddr (cnt[LAW-1:0]),
    .rdata (lram_rdata)
  );

  dlc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  dlc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .st    (div_st),
    .q     (div_q)
  );

  // operand selection for the shared units
  always_comb begin
    mul_state = 1'b1;
    mul_a = 128'(w);
    mul_b = 64'(w);
    mul_ctl.na = 3'd1;
    mul_ctl.nb = 2'd1;
    case (state)
      dlc_pkg::S_D_M1: mul_b = 64'(dram_rdata[31:0]);
      dlc_pkg::S_D_M2: begin
        mul_a = 128'(t1); mul_b = t1; mul_ctl.na = 3'd2; mul_ctl.nb = 2'd2;
      end
      dlc_pkg::S_D_M3: begin
        mul_a = 128'(ep); mul_b = 64'(ep);
      end
      dlc_pkg::S_D_M4: begin
        mul_a = 128'(t1); mul_b = 64'(eg); mul_ctl.na = 3'd2;
      end
      dlc_pkg::S_L_M1: mul_b = 64'(lram_rdata[63:32]);
      dlc_pkg::S_L_M2, dlc_pkg::S_L_M4, dlc_pkg::S_L_M8: begin
        mul_a = 128'(t1); mul_b = t1; mul_ctl.na = 3'd2; mul_ctl.nb = 2'd2;
      end
      dlc_pkg::S_L_M3: mul_b = 64'(es);
      dlc_pkg::S_L_M5: begin
        mul_a = t128; mul_b = 64'(eg); mul_ctl.na = 3'd4;
      end
      dlc_pkg::S_L_M6: begin
        mul_a = 128'(ex); mul_b = 64'(ex);
      end
      dlc_pkg::S_L_M7: ;
      default: mul_state = 1'b0;
    endcase
    mul_ctl.start = mul_state && !issued;
  end

  always_comb begin
    div_state = (state == dlc_pkg::S_D_DIV) || (state == dlc_pkg::S_L_DIV)
             || (state == dlc_pkg::S_NORM);
    div_start = div_state && !issued && !(state == dlc_pkg::S_NORM && sat);
    if (state == dlc_pkg::S_NORM) begin
      div_n = 160'(sum) << FRAC_BITS;
      div_d = 129'(normalization);
    end else begin
      div_n = num_r;
      div_d = den_r;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dlc_pkg::S_IDLE: begin
        if (accept && req_data.kind == dlc_pkg::KIND_EVAL) begin
          if (nd != 7'd0) state_next = dlc_pkg::S_D_RD;
          else if (nl != 7'd0) state_next = dlc_pkg::S_L_RD;
          else state_next = dlc_pkg::S_NORM;
        end
      end
      dlc_pkg::S_D_RD: state_next = dlc_pkg::S_D_M1;
      dlc_pkg::S_L_RD: state_next = dlc_pkg::S_L_M1;
      dlc_pkg::S_D_M1: if (mul_done) state_next = dlc_pkg::S_D_M2;
      dlc_pkg::S_D_M2: if (mul_done) state_next = dlc_pkg::S_D_M3;
      dlc_pkg::S_D_M3: if (mul_done) state_next = dlc_pkg::S_D_M4;
      dlc_pkg::S_D_M4: if (mul_done) state_next = dlc_pkg::S_D_DIV;
      dlc_pkg::S_D_DIV: begin
        if (div_st.done) begin
          if (cnt_inc != nd) state_next = dlc_pkg::S_D_RD;
          else if (nl != 7'd0) state_next = dlc_pkg::S_L_RD;
          else state_next = dlc_pkg::S_NORM;
        end
      end
      dlc_pkg::S_L_M1: if (mul_done) state_next = dlc_pkg::S_L_M2;
      dlc_pkg::S_L_M2: if (mul_done) state_next = dlc_pkg::S_L_M3;
      dlc_pkg::S_L_M3: if (mul_done) state_next = dlc_pkg::S_L_M4;
      dlc_pkg::S_L_M4: if (mul_done) state_next = dlc_pkg::S_L_M5;
      dlc_pkg::S_L_M5: if (mul_done) state_next = dlc_pkg::S_L_M6;
      dlc_pkg::S_L_M6: if (mul_done) state_next = dlc_pkg::S_L_M7;
      dlc_pkg::S_L_M7: if (mul_done) state_next = dlc_pkg::S_L_M8;
      dlc_pkg::S_L_M8: if (mul_done) state_next = dlc_pkg::S_L_DIV;
      dlc_pkg::S_L_DIV: begin
        if (div_st.done) begin
          state_next = (cnt_inc != nl) ? dlc_pkg::S_L_RD : dlc_pkg::S_NORM;
        end
      end
      dlc_pkg::S_NORM: begin
        if ((sat && !issued) || div_st.done) state_next = dlc_pkg::S_FIN;
      end
      dlc_pkg::S_FIN: if (res_load) state_next = dlc_pkg::S_IDLE;
      default: state_next = dlc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drude_terms   <= 5'd0;
      lorentz_terms <= 5'd0;
      normalization <= 32'd1 << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        dlc_pkg::CFG_DRUDE_TERMS:   drude_terms   <= cfg_data[4:0];
        dlc_pkg::CFG_LORENTZ_TERMS: lorentz_terms <= cfg_data[4:0];
        dlc_pkg::CFG_NORMALIZATION: normalization <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (mul_ctl.start || div_start) issued <= 1'b1;
      else if (mul_done || div_st.done) issued <= 1'b0;
      if (res_load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data.conductivity <= sat ? 32'hFFFF_FFFF : res_q;
      res_data.overflow     <= sat;
    end
    case (state)
      dlc_pkg::S_IDLE: begin
        w   <= req_data.frequency;
        cnt <= 7'd0;
        sum <= 64'd0;
        sat <= 1'b0;
      end
      dlc_pkg::S_D_M1: begin
        if (!issued) begin
          ep <= dram_rdata[63:32];
          eg <= dram_rdata[31:0];
        end
        if (mul_done) t1 <= mul_p[63:0];
      end
      dlc_pkg::S_D_M2: if (mul_done) den_r <= 129'(mul_p[127:0]) + (129'(1) << (4 * FRAC_BITS));
      dlc_pkg::S_D_M3: if (mul_done) t1 <= mul_p[63:0];
      dlc_pkg::S_D_M4: if (mul_done) num_r <= 160'(mul_p[95:0]) << (2 * FRAC_BITS);
      dlc_pkg::S_L_M1: begin
        if (!issued) begin
          ex <= lram_rdata[95:64];
          eg <= lram_rdata[63:32];
          es <= lram_rdata[31:0];
        end
        if (mul_done) t1 <= mul_p[63:0];
      end
      dlc_pkg::S_L_M2: if (mul_done) den_r <= 129'(mul_p[127:0]);
      dlc_pkg::S_L_M3: if (mul_done) t1 <= mul_p[63:0];
      dlc_pkg::S_L_M4: if (mul_done) t128 <= mul_p[127:0];
      dlc_pkg::S_L_M5: if (mul_done) num_r <= mul_p[159:0];
      dlc_pkg::S_L_M6: if (mul_done) t2 <= mul_p[63:0];
      dlc_pkg::S_L_M7: if (mul_done) t1 <= diff;
      dlc_pkg::S_L_M8: if (mul_done) den_r <= den_r + 129'(mul_p[127:0]);
      dlc_pkg::S_D_DIV, dlc_pkg::S_L_DIV: begin
        if (div_st.done) begin
          sum <= sum_add[63:0];
          sat <= sat | div_st.big | sum_add[64];
          if (state == dlc_pkg::S_D_DIV && cnt_inc == nd) cnt <= 7'd0;
          else cnt <= cnt_inc;
        end
      end
      dlc_pkg::S_NORM: begin
        if (div_st.done) begin
          sat   <= sat | div_st.big | (div_q[63:32] != 32'd0);
          res_q <= div_q[31:0];
        end
      end
      default: ;
    endcase
  end

  a_issue_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (issued && mul_state))
    else $error("multiplier result with no operation outstanding");

  a_issue_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (issued && div_state))
    else $error("divider result with no operation outstanding");

  a_res_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == dlc_pkg::S_FIN)
    else $error("result raised outside the finish step");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == dlc_pkg::S_D_RD) |-> (cnt < nd))
    else $error("drude read beyond term count");

  a_lcnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == dlc_pkg::S_L_RD) |-> (cnt < nl))
    else $error("oscillator read beyond term count");

endmodule

### rtl/dlc_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module dlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/dlc_mul.sv
// Multi-limb multiplier: up to 4x2 limbs of 32 bits over one 32x32 multiplier,
// one partial product a cycle, accumulated into a 192-bit register.
// Depends on dlc_pkg.
module dlc_mul (
  input  logic              clk,
  input  logic              rst,
  input  dlc_pkg::mul_req_t ctl,
  input  logic [127:0]      a,
  input  logic [63:0]       b,
  output logic              done,
  output logic [191:0]      p
);

  logic [127:0] a_r;
  logic [63:0]  b_r;
  logic [1:0]   na_m1;
  logic         nb_m1;
  logic [1:0]   i;
  logic         j;
  logic         run;
  logic         pv;
  logic         plast;
  logic [2:0]   psh;
  logic [63:0]  prod;
  logic         last;

  assign last = (i == na_m1) && (j == nb_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= pv && plast && !ctl.start;
      if (ctl.start) begin
        run <= 1'b1;
        pv  <= 1'b0;
      end else begin
        pv <= run;
        if (run && last) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= a;
      b_r   <= b;
      na_m1 <= 2'(ctl.na - 3'd1);
      nb_m1 <= 1'(ctl.nb - 2'd1);
      i     <= 2'd0;
      j     <= 1'b0;
      p     <= '0;
    end else begin
      if (run) begin
        prod  <= a_r[{i, 5'd0} +: 32] * b_r[{j, 5'd0} +: 32];
        psh   <= 3'(i) + 3'(j);
        plast <= last;
        if (j == nb_m1) begin
          j <= 1'b0;
          i <= i + 2'd1;
        end else begin
          j <= j + 1'b1;
        end
      end
      if (pv) begin
        p <= p + (192'(prod) << {psh, 5'd0});
      end
    end
  end

endmodule

### rtl/dlc_div.sv
// Restoring divider: 160-bit dividend over 129-bit divisor, 64-bit quotient,
// one bit a cycle; flags zero divisor or a quotient of 2^64 or more.
// Depends on dlc_pkg.
module dlc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [159:0]       n,
  input  logic [128:0]       d,
  output dlc_pkg::div_stat_t st,
  output logic [63:0]        q
);

  logic [128:0] rem;
  logic [128:0] d_r;
  logic [63:0]  nq;
  logic [6:0]   cnt;
  logic         run;
  logic [129:0] t;
  logic [129:0] t_sub;
  logic         ge;
  logic         pre_big;

  assign t       = {rem, nq[63]};
  assign t_sub   = t - {1'b0, d_r};
  assign ge      = (t >= {1'b0, d_r});
  assign pre_big = (d == '0) || ({33'd0, n[159:64]} >= d);
  assign q       = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      st.done <= 1'b0;
      st.big  <= 1'b0;
    end else begin
      st.done <= 1'b0;
      if (start) begin
        st.big <= pre_big;
        if (pre_big) begin
          st.done <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run && cnt == 7'd1) begin
        run     <= 1'b0;
        st.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 129'(n[159:64]);
      nq  <= n[63:0];
      d_r <= d;
      cnt <= 7'd64;
    end else if (run) begin
      cnt <= cnt - 7'd1;
      if (ge) begin
        rem <= t_sub[128:0];
        nq  <= {nq[62:0], 1'b1};
      end else begin
        rem <= t[128:0];
        nq  <= {nq[62:0], 1'b0};
      end
    end
  end

endmodule
